// ===== rtl/tr4_pkg.sv =====
// Shared types, action codes and constants of the tiled 4bpp rectangle drawer.
`default_nettype none

package tr4_pkg;

   // Default number of 8x8 tiles that the store holds.
   localparam int MAX_TILES_DEF = 64;

   // Canvas coordinates never exceed 63, since the canvas is at most 64x64.
   localparam int COORD_W = 6;

   // Action codes carried by an item.
   localparam logic [2:0] ACT_CLEAR   = 3'd0;
   localparam logic [2:0] ACT_PIXEL   = 3'd1;
   localparam logic [2:0] ACT_OUTLINE = 3'd2;
   localparam logic [2:0] ACT_FILLED  = 3'd3;
   localparam logic [2:0] ACT_READ    = 3'd4;

   // Register indexes of the configuration port.
   localparam logic CSR_WIDTH_CODE  = 1'b0;
   localparam logic CSR_HEIGHT_CODE = 1'b1;

   // Mask of one pixel nibble inside a stored word.
   localparam logic [15:0] NIB_MASK = 16'h000F;

   // Command from the control logic to the rectangle walker.
   typedef struct packed {
      logic               start;
      logic               outline;
      logic [COORD_W-1:0] x_lo;
      logic [COORD_W-1:0] x_hi;
      logic [COORD_W-1:0] y_lo;
      logic [COORD_W-1:0] y_hi;
   } walk_cmd_type;

   // Status and current pixel of the rectangle walker.
   typedef struct packed {
      logic               busy;
      logic               pix_valid;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } walk_stat_type;

endpackage

`default_nettype wire

// ===== rtl/tr4_store.sv =====
// Tile word store: one write port and one read port with registered read data.
`default_nettype none

module tr4_store #(
   parameter int Depth = 1024,
   localparam int AddrW = $clog2(Depth)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [15:0]      wr_data,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [15:0]      rd_data
);

   logic [15:0] mem [Depth];

   // A read of an address written in the same cycle returns the old word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tr4_walk.sv =====
// Rectangle walker: steps through a clipped box row by row, one pixel a cycle.
`default_nettype none

module tr4_walk import tr4_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire walk_cmd_type  cmd,
   output walk_stat_type      stat
);

   logic               busy_ff, busy_in;
   logic               outline_ff, outline_in;
   logic [COORD_W-1:0] x_lo_ff, x_lo_in;
   logic [COORD_W-1:0] x_hi_ff, x_hi_in;
   logic [COORD_W-1:0] y_lo_ff, y_lo_in;
   logic [COORD_W-1:0] y_hi_ff, y_hi_in;
   logic [COORD_W-1:0] x_ff, x_in;
   logic [COORD_W-1:0] y_ff, y_in;
   logic               on_border;

   always_comb begin
      busy_in    = busy_ff;
      outline_in = outline_ff;
      x_lo_in    = x_lo_ff;
      x_hi_in    = x_hi_ff;
      y_lo_in    = y_lo_ff;
      y_hi_in    = y_hi_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      if (cmd.start) begin
         busy_in    = 1'b1;
         outline_in = cmd.outline;
         x_lo_in    = cmd.x_lo;
         x_hi_in    = cmd.x_hi;
         y_lo_in    = cmd.y_lo;
         y_hi_in    = cmd.y_hi;
         x_in       = cmd.x_lo;
         y_in       = cmd.y_lo;
      end else if (busy_ff) begin
         if (x_ff == x_hi_ff) begin
            x_in = x_lo_ff;
            if (y_ff == y_hi_ff) begin
               busy_in = 1'b0;
            end else begin
               y_in = y_ff + 1'b1;
            end
         end else begin
            x_in = x_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      outline_ff <= outline_in;
      x_lo_ff    <= x_lo_in;
      x_hi_ff    <= x_hi_in;
      y_lo_ff    <= y_lo_in;
      y_hi_ff    <= y_hi_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
   end

   // An outline only emits the cells on the edges of the clipped box.
   assign on_border = (x_ff == x_lo_ff) || (x_ff == x_hi_ff) ||
                      (y_ff == y_lo_ff) || (y_ff == y_hi_ff);

   assign stat.busy      = busy_ff;
   assign stat.pix_valid = busy_ff && (!outline_ff || on_border);
   assign stat.x         = x_ff;
   assign stat.y         = y_ff;

endmodule

`default_nettype wire

// ===== rtl/tiled_4bpp_rect_drawer_top.sv =====
// Top level of the tiled 4bpp rectangle drawer: control, read-modify-write and handshakes.
//
//   channel   direction   ports                                  handshake
//   req_      in          action pos_x pos_y rect_w rect_h       req_valid / req_stall
//                         color read_addr
//   rsp_      out         read_data read_valid                   rsp_valid / rsp_stall
//   csr_      in          index wr_data                          csr_wr_en
//
// Per item: a clear writes min(16 << (width_code + height_code), MAX_TILES * 16) words,
// one word written per cycle. A pixel, outline or filled rectangle steps the walker one cell a
// cycle through every cell of the clipped bounding box, using the single store port pair.
// A read fetches one store word; an empty rectangle or unused action writes nothing.
// After reset the block sweeps zeros through all MAX_TILES * 16 words, one per cycle, with
// req_stall high; configuration writes are taken during the sweep.
// req_stall is high whenever an item is in progress. A finished result waits in the output
// register while the next item is accepted; rsp_stall only holds back the end of the next item.
`default_nettype none

module tiled_4bpp_rect_drawer_top import tr4_pkg::*; #(
   parameter int MAX_TILES = MAX_TILES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // Item input channel.
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [2:0]        req_action,
   input  wire logic signed [7:0] req_pos_x,
   input  wire logic signed [7:0] req_pos_y,
   input  wire logic signed [7:0] req_rect_w,
   input  wire logic signed [7:0] req_rect_h,
   input  wire logic [3:0]        req_color,
   input  wire logic [9:0]        req_read_addr,
   // Result channel.
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [15:0]            rsp_read_data,
   output logic                   rsp_read_valid,
   // Configuration write port.
   input  wire logic              csr_wr_en,
   input  wire logic              csr_index,
   input  wire logic [1:0]        csr_wr_data
);

   localparam int STORE_WORDS = MAX_TILES * 16;
   localparam int ADDR_W      = $clog2(STORE_WORDS);
   localparam int CNT_W       = ADDR_W + 1;

   // Control states.
   localparam logic [2:0] ST_SWEEP  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_CLEAR  = 3'd2;
   localparam logic [2:0] ST_DRAW   = 3'd3;
   localparam logic [2:0] ST_READ   = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   // Clips one axis of a rectangle against the canvas size given by its code.
   // Returns {nonempty, first cell, last cell}.
   function automatic logic [2*COORD_W:0] clip_axis(input logic signed [7:0] pos,
                                                    input logic signed [7:0] len,
                                                    input logic [1:0] code);
      logic        [6:0]  size;
      logic signed [10:0] first;
      logic signed [10:0] stop;
      logic signed [10:0] lim;
      logic signed [10:0] last;
      size  = 7'd8 << code;
      lim   = signed'({4'b0000, size});
      first = signed'({{3{pos[7]}}, pos});
      stop  = first + signed'({{3{len[7]}}, len});
      if (first < 0) begin
         first = '0;
      end
      if (stop > lim) begin
         stop = lim;
      end
      last = stop - 11'sd1;
      return {(stop > first), first[COORD_W-1:0], last[COORD_W-1:0]};
   endfunction

   logic [2:0]        state_ff, state_in;
   logic [1:0]        width_code_ff, width_code_in;
   logic [1:0]        height_code_ff, height_code_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  limit_ff, limit_in;
   logic [15:0]       fill_ff, fill_in;
   logic [3:0]        color_ff, color_in;
   logic              rd_hit_ff, rd_hit_in;
   logic [ADDR_W-1:0] rd_addr_ff;
   logic              p1_valid_ff, p1_valid_in;
   logic [1:0]        p1_nib_ff, p1_nib_in;
   logic [15:0]       res_data_ff, res_data_in;
   logic              res_valid_ff, res_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_data_ff, rsp_data_in;
   logic              rsp_rvalid_ff, rsp_rvalid_in;
   logic              wr_prev_en_ff;
   logic [ADDR_W-1:0] wr_prev_addr_ff;
   logic [15:0]       wr_prev_data_ff;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [15:0]       mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;
   logic [15:0]       mem_rdata;

   walk_cmd_type      walk_cmd;
   walk_stat_type     walk_stat;

   logic              accept;
   logic              is_draw;
   logic signed [7:0] ext_w, ext_h;
   logic [2*COORD_W:0] clip_x, clip_y;
   logic              draw_ok;
   logic [10:0]       clr_words;
   logic [10:0]       clr_limit;
   logic              read_in_range;
   logic [5:0]        pix_tile;
   logic              pix_tile_ok;
   logic [9:0]        pix_addr;
   logic [15:0]       merged;
   logic [3:0]        nib_shift;
   logic [15:0]       pix_word;
   logic              rsp_load;

   tr4_store #(
      .Depth(STORE_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   tr4_walk u_walk (
      .clock (clock),
      .reset (reset),
      .cmd   (walk_cmd),
      .stat  (walk_stat)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // A single pixel is a one by one filled rectangle; clipping then drops it off canvas.
   assign is_draw = (req_action == ACT_PIXEL) || (req_action == ACT_OUTLINE) ||
                    (req_action == ACT_FILLED);
   assign ext_w   = (req_action == ACT_PIXEL) ? 8'sd1 : req_rect_w;
   assign ext_h   = (req_action == ACT_PIXEL) ? 8'sd1 : req_rect_h;
   assign clip_x  = clip_axis(req_pos_x, ext_w, width_code_ff);
   assign clip_y  = clip_axis(req_pos_y, ext_h, height_code_ff);
   assign draw_ok = clip_x[2*COORD_W] && clip_y[2*COORD_W];

   // Words covered by a clear: sixteen per canvas tile, capped by the store size.
   assign clr_words = 11'd16 << ({1'b0, width_code_ff} + {1'b0, height_code_ff});
   assign clr_limit = (clr_words > 11'(STORE_WORDS)) ? 11'(STORE_WORDS) : clr_words;

   assign read_in_range = ({1'b0, req_read_addr} < 11'(STORE_WORDS));

   // Tile index is column tile plus row tile times tiles per row; both fit in six bits.
   assign pix_tile    = {3'b000, walk_stat.x[5:3]} | ({3'b000, walk_stat.y[5:3]} << width_code_ff);
   assign pix_tile_ok = ({1'b0, pix_tile} < 7'(MAX_TILES));
   assign pix_addr    = {pix_tile, walk_stat.y[2:0], walk_stat.x[2]};

   // A word written in the cycle its read was issued is taken from the write register.
   assign merged = (wr_prev_en_ff && (wr_prev_addr_ff == rd_addr_ff)) ? wr_prev_data_ff
                                                                      : mem_rdata;
   assign nib_shift = {p1_nib_ff, 2'b00};
   assign pix_word  = (merged & ~(NIB_MASK << nib_shift)) |
                      ((NIB_MASK & {12'h000, color_ff}) << nib_shift);

   assign walk_cmd.start   = accept && is_draw && draw_ok;
   assign walk_cmd.outline = (req_action == ACT_OUTLINE);
   assign walk_cmd.x_lo    = clip_x[2*COORD_W-1:COORD_W];
   assign walk_cmd.x_hi    = clip_x[COORD_W-1:0];
   assign walk_cmd.y_lo    = clip_y[2*COORD_W-1:COORD_W];
   assign walk_cmd.y_hi    = clip_y[COORD_W-1:0];

   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in       = state_ff;
      width_code_in  = width_code_ff;
      height_code_in = height_code_ff;
      cnt_in         = cnt_ff;
      limit_in       = limit_ff;
      fill_in        = fill_ff;
      color_in       = color_ff;
      rd_hit_in      = rd_hit_ff;
      p1_valid_in    = 1'b0;
      p1_nib_in      = p1_nib_ff;
      res_data_in    = res_data_ff;
      res_valid_in   = res_valid_ff;
      mem_we         = 1'b0;
      mem_waddr      = cnt_ff[ADDR_W-1:0];
      mem_wdata      = fill_ff;
      mem_re         = 1'b0;
      mem_raddr      = pix_addr[ADDR_W-1:0];

      if (csr_wr_en) begin
         if (csr_index == CSR_WIDTH_CODE) begin
            width_code_in = csr_wr_data;
         end else begin
            height_code_in = csr_wr_data;
         end
      end

      case (state_ff)
         ST_SWEEP, ST_CLEAR: begin
            mem_we = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_in == limit_ff) begin
               state_in = (state_ff == ST_SWEEP) ? ST_IDLE : ST_FINISH;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               res_data_in  = '0;
               res_valid_in = 1'b0;
               color_in     = req_color;
               if (req_action == ACT_CLEAR) begin
                  fill_in  = {4{req_color}};
                  cnt_in   = '0;
                  limit_in = clr_limit[CNT_W-1:0];
                  state_in = ST_CLEAR;
               end else if (is_draw) begin
                  state_in = draw_ok ? ST_DRAW : ST_FINISH;
               end else if (req_action == ACT_READ) begin
                  res_valid_in = 1'b1;
                  rd_hit_in    = read_in_range;
                  mem_re       = read_in_range;
                  mem_raddr    = req_read_addr[ADDR_W-1:0];
                  state_in     = ST_READ;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_DRAW: begin
            // Stage one issues the read of the current cell, stage two writes it back.
            if (walk_stat.pix_valid && pix_tile_ok) begin
               mem_re      = 1'b1;
               p1_valid_in = 1'b1;
               p1_nib_in   = walk_stat.x[1:0];
            end
            if (p1_valid_ff) begin
               mem_we    = 1'b1;
               mem_waddr = rd_addr_ff;
               mem_wdata = pix_word;
            end
            if (!walk_stat.busy && !p1_valid_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_READ: begin
            res_data_in = rd_hit_ff ? merged : 16'h0000;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      rsp_rvalid_in = rsp_rvalid_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = res_data_ff;
         rsp_rvalid_in = res_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_SWEEP;
         width_code_ff  <= 2'd0;
         height_code_ff <= 2'd0;
         cnt_ff         <= '0;
         limit_ff       <= CNT_W'(STORE_WORDS);
         fill_ff        <= 16'h0000;
         p1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         wr_prev_en_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         width_code_ff  <= width_code_in;
         height_code_ff <= height_code_in;
         cnt_ff         <= cnt_in;
         limit_ff       <= limit_in;
         fill_ff        <= fill_in;
         p1_valid_ff    <= p1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         wr_prev_en_ff  <= mem_we;
      end
      color_ff        <= color_in;
      rd_hit_ff       <= rd_hit_in;
      p1_nib_ff       <= p1_nib_in;
      res_data_ff     <= res_data_in;
      res_valid_ff    <= res_valid_in;
      rsp_data_ff     <= rsp_data_in;
      rsp_rvalid_ff   <= rsp_rvalid_in;
      wr_prev_addr_ff <= mem_waddr;
      wr_prev_data_ff <= mem_wdata;
      if (mem_re) begin
         rd_addr_ff <= mem_raddr;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_read_valid = rsp_rvalid_ff;

   // The write-back stage only carries a cell while a rectangle is being drawn.
   a_p1_in_draw: assert property (@(posedge clock) disable iff (reset)
      p1_valid_ff |-> (state_ff == ST_DRAW))
      else $error("write-back stage active outside drawing");

   // The walker runs only while the control logic waits for it.
   a_walk_in_draw: assert property (@(posedge clock) disable iff (reset)
      walk_stat.busy |-> (state_ff == ST_DRAW))
      else $error("walker busy outside drawing");

   // Nothing is written to the store while the block waits for an item.
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_we)
      else $error("store written while idle");

   // An accepted read always enters the read state with its result marked valid.
   a_read_result: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_action == ACT_READ)) |=> (state_ff == ST_READ) && res_valid_ff)
      else $error("read item did not enter the read state");

endmodule

`default_nettype wire
